// ===== design/stlb_pkg.sv =====
// stlb_pkg: shared constants, codes, types and helpers of the scrolling text line buffer
// depends on nothing; used by every other file of the block but stlb_ram
package stlb_pkg;

	localparam int MAX_LINES  = 22;
	localparam int LINE_CAP   = 96;
	// one extra slot holds the partial line, so a commit never copies text
	localparam int RING_SLOTS = MAX_LINES + 1;

	localparam int SLOT_W     = $clog2(RING_SLOTS);
	localparam int COL_W      = $clog2(LINE_CAP);
	localparam int COUNT_W    = $clog2(MAX_LINES + 1);
	localparam int LINE_IDX_W = 5;
	localparam int OP_W       = 2;
	localparam int BYTE_W     = 8;
	localparam int RAM_DEPTH  = RING_SLOTS * LINE_CAP;
	localparam int ADDR_W     = $clog2(RAM_DEPTH);

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [BYTE_W-1:0] CH_LF          = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR          = 8'd13;
	localparam logic [BYTE_W-1:0] CH_SPACE       = 8'd32;
	localparam logic [BYTE_W-1:0] CH_FIRST_PRINT = 8'd32;
	localparam logic [BYTE_W-1:0] CH_DEL         = 8'd127;

	typedef struct packed {
		logic accept;     // input transaction taken this cycle
		logic load_read;  // ram read data is valid this cycle
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_read;    // offered item is a read op
	} dp_status_t;

	function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W:0] s);
		if (s >= (SLOT_W+1)'(RING_SLOTS))
			return SLOT_W'(s - (SLOT_W+1)'(RING_SLOTS));
		else
			return SLOT_W'(s);
	endfunction

	function automatic logic [BYTE_W-1:0] clean_byte(input logic [BYTE_W-1:0] b);
		return (b >= CH_FIRST_PRINT && b < CH_DEL) ? b : CH_SPACE;
	endfunction

endpackage

// ===== design/stlb_if.sv =====
// stlb_if: valid/ready channel interfaces for input ops and result items
// depends on stlb_pkg for field widths
interface stlb_in_if;
	logic                              valid;
	logic                              ready;
	logic [stlb_pkg::OP_W-1:0]         op;
	logic [stlb_pkg::BYTE_W-1:0]       byte_value;
	logic                              end_of_chunk;
	logic [stlb_pkg::LINE_IDX_W-1:0]   line_index;
	logic [stlb_pkg::COL_W-1:0]        column;

	modport source (output valid, op, byte_value, end_of_chunk, line_index, column,
		input ready);
	modport sink (input valid, op, byte_value, end_of_chunk, line_index, column,
		output ready);
endinterface

interface stlb_out_if;
	logic                              valid;
	logic                              ready;
	logic [stlb_pkg::BYTE_W-1:0]       read_char;
	logic [stlb_pkg::COUNT_W-1:0]      line_count;
	logic [stlb_pkg::COL_W-1:0]        build_length;
	logic                              repaint;

	modport source (output valid, read_char, line_count, build_length, repaint,
		input ready);
	modport sink (input valid, read_char, line_count, build_length, repaint,
		output ready);
endinterface

// ===== design/scrolling_text_line_buffer.sv =====
// scrolling_text_line_buffer: console text log, ring of lines plus a partial line
// write, clear and unused ops go from accept straight to S_OUT with their result; reads
// first pass S_WAIT for the registered read of the character ram; one item in flight, so
// no new op is accepted until the result in S_OUT has been taken
// reset: arst_n clears log_enable, counts, ring start and newline flag at once;
// character and length stores are not cleared and hold nothing readable until written
module scrolling_text_line_buffer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	stlb_in_if.sink            in_ch,
	stlb_out_if.source         out_ch
);

	stlb_pkg::ctrl_cmd_t  cmd;
	stlb_pkg::dp_status_t status;

	stlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	stlb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.status       (status),
		.op           (in_ch.op),
		.byte_value   (in_ch.byte_value),
		.end_of_chunk (in_ch.end_of_chunk),
		.line_index   (in_ch.line_index),
		.column       (in_ch.column),
		.read_char    (out_ch.read_char),
		.line_count   (out_ch.line_count),
		.build_length (out_ch.build_length),
		.repaint      (out_ch.repaint)
	);

endmodule

// ===== design/stlb_ram.sv =====
// stlb_ram: generic single-write, single-read ram with registered read data
// no dependencies
module stlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/stlb_ctrl.sv =====
// stlb_ctrl: handshake controller, sequences accept, ram read wait and result hold
// depends on stlb_pkg for command and status types
module stlb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  stlb_pkg::dp_status_t   status,
	output stlb_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WAIT = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q, state_d;

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd.accept    = 1'b0;
		cmd.load_read = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.is_read ? S_WAIT : S_OUT;
				end
			end
			S_WAIT: begin
				cmd.load_read = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== design/stlb_dp.sv =====
// stlb_dp: line ring state, partial line append, commit and read addressing
// depends on stlb_pkg and stlb_ram (character store)
module stlb_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  stlb_pkg::ctrl_cmd_t                cmd,
	output stlb_pkg::dp_status_t               status,
	input  logic [stlb_pkg::OP_W-1:0]          op,
	input  logic [stlb_pkg::BYTE_W-1:0]        byte_value,
	input  logic                               end_of_chunk,
	input  logic [stlb_pkg::LINE_IDX_W-1:0]    line_index,
	input  logic [stlb_pkg::COL_W-1:0]         column,
	output logic [stlb_pkg::BYTE_W-1:0]        read_char,
	output logic [stlb_pkg::COUNT_W-1:0]       line_count,
	output logic [stlb_pkg::COL_W-1:0]         build_length,
	output logic                               repaint
);

	localparam int SW = stlb_pkg::SLOT_W;
	localparam int CW = stlb_pkg::COL_W;
	localparam int NW = stlb_pkg::COUNT_W;
	localparam int AW = stlb_pkg::ADDR_W;

	logic          log_enable_q;
	logic [SW-1:0] oldest_q, oldest_d;
	logic [NW-1:0] stored_q, stored_d;
	logic [CW-1:0] plen_q, plen_d;
	logic          newline_q, newline_d;
	logic [CW-1:0] len_q [stlb_pkg::RING_SLOTS];

	logic [stlb_pkg::BYTE_W-1:0] read_char_q;
	logic [NW-1:0]               line_count_q;
	logic [CW-1:0]               build_length_q;
	logic                        repaint_q;
	logic                        rd_hit_q;

	logic [SW-1:0] head_slot, line_slot, rd_slot;
	logic          rd_hit, repaint_d;
	logic          ram_we, len_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [stlb_pkg::BYTE_W-1:0] ram_rdata;

	// partial line lives in the slot just past the newest stored line
	assign head_slot = stlb_pkg::wrap_slot((SW+1)'(oldest_q) + (SW+1)'(stored_q));
	assign line_slot = stlb_pkg::wrap_slot((SW+1)'(oldest_q) + (SW+1)'(line_index));

	assign status.is_read = (op == stlb_pkg::OP_READ);

	always_comb begin
		rd_slot = head_slot;
		rd_hit  = 1'b0;
		if ((NW+1)'(line_index) < (NW+1)'(stored_q)) begin
			rd_slot = line_slot;
			rd_hit  = column < len_q[line_slot];
		end else if ((NW+1)'(line_index) == (NW+1)'(stored_q)) begin
			rd_hit = column < plen_q;
		end
	end

	always_comb begin
		oldest_d  = oldest_q;
		stored_d  = stored_q;
		plen_d    = plen_q;
		newline_d = newline_q;
		repaint_d = 1'b0;
		ram_we    = 1'b0;
		len_we    = 1'b0;
		unique case (op)
			stlb_pkg::OP_WRITE: begin
				if (log_enable_q) begin
					if (byte_value == stlb_pkg::CH_LF) begin
						len_we    = cmd.accept;
						plen_d    = '0;
						newline_d = 1'b1;
						if (stored_q == NW'(stlb_pkg::MAX_LINES))
							oldest_d = stlb_pkg::wrap_slot((SW+1)'(oldest_q) + (SW+1)'(1));
						else
							stored_d = stored_q + NW'(1);
					end else if (byte_value != stlb_pkg::CH_CR) begin
						if (plen_q < CW'(stlb_pkg::LINE_CAP - 1)) begin
							ram_we = cmd.accept;
							plen_d = plen_q + CW'(1);
						end
					end
					if (end_of_chunk)
						repaint_d = newline_d;
				end
				if (end_of_chunk)
					newline_d = 1'b0;
			end
			stlb_pkg::OP_CLEAR: begin
				oldest_d  = '0;
				stored_d  = '0;
				plen_d    = '0;
				newline_d = 1'b0;
			end
			default: ;
		endcase
	end

	assign ram_waddr = AW'(head_slot) * AW'(stlb_pkg::LINE_CAP) + AW'(plen_q);
	assign ram_raddr = AW'(rd_slot) * AW'(stlb_pkg::LINE_CAP) + AW'(column);

	stlb_ram #(
		.WIDTH (stlb_pkg::BYTE_W),
		.DEPTH (stlb_pkg::RAM_DEPTH)
	) u_chars (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (stlb_pkg::clean_byte(byte_value)),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_enable_q <= 1'b0;
			oldest_q     <= '0;
			stored_q     <= '0;
			plen_q       <= '0;
			newline_q    <= 1'b0;
		end else begin
			if (cfg_we)
				log_enable_q <= cfg_wdata;
			if (cmd.accept) begin
				oldest_q  <= oldest_d;
				stored_q  <= stored_d;
				plen_q    <= plen_d;
				newline_q <= newline_d;
			end
		end
	end

	// line lengths and result fields are payload, no reset
	always_ff @(posedge clk) begin
		if (len_we)
			len_q[head_slot] <= plen_q;
		if (cmd.accept) begin
			read_char_q    <= '0;
			rd_hit_q       <= rd_hit;
			line_count_q   <= stored_d;
			build_length_q <= plen_d;
			repaint_q      <= repaint_d;
		end
		if (cmd.load_read)
			read_char_q <= rd_hit_q ? ram_rdata : '0;
	end

	assign read_char    = read_char_q;
	assign line_count   = line_count_q;
	assign build_length = build_length_q;
	assign repaint      = repaint_q;

endmodule
